// ----- rtl/imvs_pkg.sv -----
package imvs_pkg;

    localparam int MAX_VECTOR = 1024;
    localparam int VEC_AW     = $clog2(MAX_VECTOR);

    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 8;
    localparam int SCALE_W    = 32;
    localparam int VLEN_W     = 11;
    localparam int ROWS_W     = 16;
    localparam int ACC_W      = 32;
    localparam int SUM_W      = ACC_W + 1;
    localparam int RESULT_W   = 61;

    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 80;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [15:0] BIAS_GAIN = 16'sd127;

    typedef enum logic [0:0] {
        REG_VECTOR_LENGTH = 1'b0,
        REG_ROW_COUNT     = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic mac;
        logic scale_load;
        logic emit;
    } ctrl_t;

endpackage

// ----- rtl/imvs_ram.sv -----
module imvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/imvs_scaler.sv -----
module imvs_scaler (
    input  logic                                     clk,
    input  logic                                     load,
    input  logic signed [imvs_pkg::SUM_W-1:0]        sum,
    input  logic        [imvs_pkg::SCALE_W-1:0]      scale,
    output logic signed [imvs_pkg::RESULT_W-1:0]     product
);

    import imvs_pkg::*;

    localparam int PART_W = SCALE_W / 2;
    localparam int PROD_W = SUM_W + PART_W + 1;
    localparam int FULL_W = SUM_W + SCALE_W + 1;

    logic signed [SUM_W-1:0]  sum_reg;
    logic        [PART_W-1:0] scale_hi_reg;
    logic signed [PROD_W-1:0] lo_prod_reg;
    logic signed [PROD_W-1:0] lo_prod_next;
    logic signed [PROD_W-1:0] hi_prod;
    logic signed [FULL_W-1:0] full;

    assign lo_prod_next = sum * $signed({1'b0, scale[PART_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg      <= sum;
            scale_hi_reg <= scale[SCALE_W-1:PART_W];
            lo_prod_reg  <= lo_prod_next;
        end
    end

    assign hi_prod = sum_reg * $signed({1'b0, scale_hi_reg});
    assign full    = {{(FULL_W-PROD_W){lo_prod_reg[PROD_W-1]}}, lo_prod_reg}
                   + {hi_prod[FULL_W-PART_W-1:0], {PART_W{1'b0}}};
    assign product = full[RESULT_W-1:0];

endmodule

// ----- rtl/int8_matrix_vector_scaled.sv -----
// Signed int8 matrix-vector multiply with per-row Q8.24 scale. Load the vector first with
// tuser=0 transactions (index and value), then stream each row as vector_length weights and
// one bias byte with tuser=1; the bias transaction carries the row scale and produces one
// result (dot + bias*127) * scale with 24 fraction bits, its row number and tlast on the last
// row of the pass. A vector load is taken in idle; a weight passes the MAC state after the
// registered vector RAM read; a bias passes the scale and emit states (sum, then a two-step
// 32-bit scale multiply), waiting in emit only while the sink holds the output register.
// Configuration writes are accepted every cycle and must only happen while the block is idle.
module int8_matrix_vector_scaled (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // element_index[9:0], element_value[17:10], row_scale[49:18], zero pad
    input  logic [imvs_pkg::S_DATA_W-1:0]        s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // scaled_result[60:0], row_index[76:61], zero pad
    output logic [imvs_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [imvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import imvs_pkg::*;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [VLEN_W-1:0]         vector_length_reg;
    logic [ROWS_W-1:0]         row_count_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [VLEN_W-1:0]         pos_reg;
    logic [ROWS_W-1:0]         row_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic                      elem_zero_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SCALE_W-1:0]        scale_reg;

    logic                      out_valid_reg;
    logic signed [RESULT_W-1:0] out_result_reg;
    logic [ROWS_W-1:0]         out_row_reg;
    logic                      out_last_reg;

    logic [INDEX_W-1:0]        in_index;
    logic signed [VALUE_W-1:0] in_value;
    logic [SCALE_W-1:0]        in_scale;
    logic                      in_kind;
    logic                      accept;
    logic                      is_weight;
    logic                      out_free;

    logic                      ram_we;
    logic                      ram_re;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] elem;
    logic signed [15:0]        mac_prod;
    logic signed [15:0]        bias_term;
    logic signed [RESULT_W-1:0] product;
    logic [ROWS_W:0]           row_limit;
    logic [ROWS_W:0]           row_plus;
    logic                      last;

    assign in_index  = s_tdata[INDEX_W-1:0];
    assign in_value  = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign in_scale  = s_tdata[INDEX_W+VALUE_W+SCALE_W-1:INDEX_W+VALUE_W];
    assign in_kind   = s_tuser;
    assign accept    = s_tvalid && s_tready;
    assign is_weight = pos_reg < vector_length_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign s_tready  = ctrl.in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind)
                begin
                    state_next = is_weight ? ST_MAC : ST_SCALE;
                end
            end
            ST_MAC:   state_next = ST_IDLE;
            ST_SCALE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:  ctrl.in_ready   = 1'b1;
            ST_MAC:   ctrl.mac        = 1'b1;
            ST_SCALE: ctrl.scale_load = 1'b1;
            ST_EMIT:  ctrl.emit       = out_free;
            default:  ctrl = '0;
        endcase
    end

    assign ram_we = accept && !in_kind && (32'(in_index) < MAX_VECTOR);
    assign ram_re = accept && in_kind && is_weight;

    imvs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_VECTOR)
    ) u_vector_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (VEC_AW'(in_index)),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (VEC_AW'(pos_reg)),
        .rdata (ram_rdata)
    );

    assign elem      = elem_zero_reg ? '0 : $signed(ram_rdata);
    assign mac_prod  = val_reg * elem;
    assign acc_next  = acc_reg + {{(ACC_W-16){mac_prod[15]}}, mac_prod};
    assign bias_term = {{8{in_value[VALUE_W-1]}}, in_value} * BIAS_GAIN;
    assign sum_next  = {acc_reg[ACC_W-1], acc_reg}
                     + {{(SUM_W-16){bias_term[15]}}, bias_term};

    imvs_scaler u_scaler (
        .clk     (clk),
        .load    (ctrl.scale_load),
        .sum     (sum_reg),
        .scale   (scale_reg),
        .product (product)
    );

    assign row_limit = (row_count_reg == '0) ? {1'b1, {ROWS_W{1'b0}}} : {1'b0, row_count_reg};
    assign row_plus  = {1'b0, row_reg} + 1'b1;
    assign last      = row_plus >= row_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            vector_length_reg <= VLEN_W'(1);
            row_count_reg     <= ROWS_W'(1);
            acc_reg           <= '0;
            pos_reg           <= '0;
            row_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_VECTOR_LENGTH: vector_length_reg <= cfg_data[VLEN_W-1:0];
                    REG_ROW_COUNT:     row_count_reg     <= cfg_data[ROWS_W-1:0];
                    default:           row_count_reg     <= row_count_reg;
                endcase
            end

            if (ram_re)
            begin
                pos_reg <= pos_reg + 1'b1;
            end

            if (ctrl.mac)
            begin
                acc_reg <= acc_next;
            end

            if (ctrl.emit)
            begin
                acc_reg       <= '0;
                pos_reg       <= '0;
                row_reg       <= last ? '0 : row_plus[ROWS_W-1:0];
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_kind)
        begin
            val_reg       <= in_value;
            elem_zero_reg <= !(32'(pos_reg) < MAX_VECTOR);
            sum_reg       <= sum_next;
            scale_reg     <= in_scale;
        end
        if (ctrl.emit)
        begin
            out_result_reg <= product;
            out_row_reg    <= row_reg;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-RESULT_W-ROWS_W){1'b0}}, out_row_reg, out_result_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- tb/sv/tb_int8_matrix_vector_scaled.sv -----
`timescale 1ns / 100ps

module tb_int8_matrix_vector_scaled;

    import imvs_pkg::*;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int LOADED        = 48;
    localparam int RUN_LIMIT_NS  = 8000000;

    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t what;
        logic        kind;
        logic [9:0]  idx;
        logic [7:0]  val;
        logic [31:0] scale;
        cfg_reg_t    cfg_sel;
        logic [15:0] cfg_val;
        logic        yields;
    } stim_entry_t;

    typedef struct packed {
        logic [60:0] scaled;
        logic [15:0] row;
        logic        last;
    } row_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    stim_entry_t stim_q [$];
    row_result_t exp_q [$];

    int   vec_model [MAX_VECTOR];
    int   acc_model    = 0;
    int   pos_model    = 0;
    int   row_model    = 0;
    int   vlen_model   = 1;
    int   rcount_model = 1;
    int   item_count   = 0;
    int   exp_total    = 0;
    int   sent_results = 0;
    int   got_results  = 0;
    int   errors       = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    logic cur_yields   = 1'b0;

    int8_matrix_vector_scaled DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [7:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return 8'h80;
        end
        if (k == 1)
        begin
            return 8'h7F;
        end
        return 8'($urandom());
    endfunction

    function automatic logic [31:0] pick_scale();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return 32'd0;
        end
        if (k == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        if (k == 2)
        begin
            return 32'h0100_0000;
        end
        return $urandom();
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
        begin
            return 0;
        end
        if (k < 95)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 40);
    endfunction

    // predicts the results while the stimulus is built
    function automatic void add_item(input logic kind, input logic [9:0] idx,
                                     input logic [7:0] val, input logic [31:0] scale);
        stim_entry_t ent;
        row_result_t res;
        int          value;
        int          limit;
        longint      sum;
        longint      prod;
        ent       = '0;
        ent.what  = ENT_ITEM;
        ent.kind  = kind;
        ent.idx   = idx;
        ent.val   = val;
        ent.scale = scale;
        value     = int'($signed(val));
        if (kind == KIND_LOAD)
        begin
            if (int'(idx) < MAX_VECTOR)
            begin
                vec_model[idx] = value;
            end
        end
        else if (pos_model < vlen_model)
        begin
            if (pos_model < MAX_VECTOR)
            begin
                acc_model = acc_model + value * vec_model[pos_model];
            end
            pos_model = (pos_model + 1) & 'h7FF;
        end
        else
        begin
            sum        = longint'(acc_model) + longint'(value) * longint'(BIAS_GAIN);
            prod       = sum * longint'(scale);
            limit      = (rcount_model == 0) ? 65536 : rcount_model;
            res.scaled = prod[RESULT_W-1:0];
            res.row    = 16'(row_model);
            res.last   = (row_model + 1) >= limit;
            exp_q.push_back(res);
            acc_model  = 0;
            pos_model  = 0;
            row_model  = res.last ? 0 : ((row_model + 1) & 'hFFFF);
            ent.yields = 1'b1;
        end
        item_count++;
        stim_q.push_back(ent);
    endfunction

    function automatic void add_cfg(input cfg_reg_t sel, input logic [15:0] value);
        stim_entry_t ent;
        ent         = '0;
        ent.what    = ENT_CFG;
        ent.cfg_sel = sel;
        ent.cfg_val = value;
        unique case (sel)
            REG_VECTOR_LENGTH: vlen_model   = int'(value[VLEN_W-1:0]);
            REG_ROW_COUNT:     rcount_model = int'(value);
        endcase
        stim_q.push_back(ent);
    endfunction

    function automatic void add_drain();
        stim_entry_t ent;
        ent      = '0;
        ent.what = ENT_DRAIN;
        stim_q.push_back(ent);
    endfunction

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin : stimulus
        int vlen;
        int rows;
        int k;
        for (int i = 0; i < LOADED; i++)
        begin
            add_item(KIND_LOAD, 10'(i), pick_value(), $urandom());
        end
        while (item_count < RANDOM_ITEMS)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
            begin
                vlen = 0;
            end
            else if (k < 8)
            begin
                vlen = $urandom_range(1, 8);
            end
            else
            begin
                vlen = $urandom_range(9, LOADED);
            end
            add_cfg(REG_VECTOR_LENGTH, 16'(vlen));
            if ($urandom_range(0, 9) == 0)
            begin
                add_cfg(REG_ROW_COUNT, 16'd0);
            end
            else
            begin
                add_cfg(REG_ROW_COUNT, 16'($urandom_range(1, 6)));
            end
            rows = $urandom_range(1, 8);
            for (int r = 0; r < rows && item_count < RANDOM_ITEMS; r++)
            begin
                for (int w = 0; w < vlen; w++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        add_item(KIND_LOAD, 10'($urandom_range(0, LOADED - 1)),
                                 pick_value(), $urandom());
                    end
                    add_item(KIND_WEIGHT, 10'($urandom()), pick_value(), $urandom());
                end
                add_item(KIND_WEIGHT, 10'($urandom()), pick_value(), pick_scale());
                if ($urandom_range(0, 9) == 0)
                begin
                    add_drain();
                end
                if ($urandom_range(0, 14) == 0)
                begin
                    add_cfg(REG_ROW_COUNT, 16'($urandom_range(1, 3)));
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                add_item(KIND_LOAD, 10'($urandom_range(LOADED, 1023)), pick_value(), $urandom());
            end
        end
        exp_total = exp_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (!(stim_q.size() == 0 && !s_tvalid && !cfg_valid && got_results == exp_total))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && exp_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin : driver
        stim_entry_t ent;
        logic        in_busy;
        logic        cfg_busy;
        logic        quiet;
        in_busy  = s_tvalid;
        cfg_busy = cfg_valid;
        if (s_tvalid && s_tready)
        begin
            in_busy = 1'b0;
            if (cur_yields)
            begin
                sent_results++;
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            cfg_busy = 1'b0;
        end
        quiet = (got_results == sent_results) && s_tready;
        if (rst_n && !in_busy && !cfg_busy && stim_q.size() > 0)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else
            begin
                ent = stim_q[0];
                unique case (ent.what)
                    ENT_ITEM:
                    begin
                        void'(stim_q.pop_front());
                        s_tdata    <= S_DATA_W'({ent.scale, ent.val, ent.idx});
                        s_tuser    <= ent.kind;
                        cur_yields  = ent.yields;
                        in_busy     = 1'b1;
                        gap_left    = pick_gap();
                    end
                    ENT_CFG:
                    begin
                        if (quiet)
                        begin
                            void'(stim_q.pop_front());
                            cfg_index <= ent.cfg_sel;
                            cfg_data  <= ent.cfg_val;
                            cfg_busy   = 1'b1;
                        end
                    end
                    ENT_DRAIN:
                    begin
                        if (got_results == sent_results)
                        begin
                            void'(stim_q.pop_front());
                        end
                    end
                    default: void'(stim_q.pop_front());
                endcase
            end
        end
        s_tvalid  <= in_busy;
        cfg_valid <= cfg_busy;
    end

    always @(posedge clk)
    begin : monitor
        row_result_t want;
        logic        ready_next;
        int          roll;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_q.size() == 0)
                begin
                    $error("unexpected transaction, row_index %0d",
                           m_tdata[RESULT_W+ROWS_W-1:RESULT_W]);
                    errors++;
                end
                else
                begin
                    want = exp_q.pop_front();
                    if (m_tdata[RESULT_W-1:0] !== want.scaled)
                    begin
                        $error("scaled_result expected %0h actual %0h",
                               want.scaled, m_tdata[RESULT_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[RESULT_W+ROWS_W-1:RESULT_W] !== want.row)
                    begin
                        $error("row_index expected %0d actual %0d",
                               want.row, m_tdata[RESULT_W+ROWS_W-1:RESULT_W]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_row expected %0b actual %0b", want.last, m_tlast);
                        errors++;
                    end
                end
                got_results <= got_results + 1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
                roll       = $urandom_range(0, 99);
                if (roll < 20)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else if (roll < 23)
                begin
                    stall_left = $urandom_range(20, 60);
                end
            end
            m_tready <= ready_next;
        end
    end

endmodule

// ----- sim.f -----
rtl/imvs_pkg.sv
rtl/imvs_ram.sv
rtl/imvs_scaler.sv
rtl/int8_matrix_vector_scaled.sv
tb/sv/tb_int8_matrix_vector_scaled.sv
